// ===== hdl/adam_pkg.sv =====
// Shared constants, types and helpers for the Adam optimizer update block.
package adam_pkg;

    localparam int SLOT_COUNT = 4096;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int MEAN_W     = 48;
    localparam int VAR_W      = 64;
    localparam int COEF_W     = 31;
    localparam int EPS_W      = 33;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 33;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COEF_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [63:0] MHAT_CAP   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] UPDATE_CAP = 64'h0000_0002_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 2'd3;

    localparam logic [COEF_W-1:0] LR_RESET  = 31'd1073742;
    localparam logic [COEF_W-1:0] B1_RESET  = 31'd966367642;
    localparam logic [COEF_W-1:0] B2_RESET  = 31'd1072668082;
    localparam logic [EPS_W-1:0]  EPS_RESET = 33'd43;

    // Control handed from the sequencer to the shared divide/root unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
    } t_unit_cmd;

    function automatic logic [COEF_W-1:0] clamp_beta(input logic [COEF_W-1:0] b);
        return (b > ONE_Q30) ? ONE_Q30 : b;
    endfunction

endpackage

// ===== hdl/adam_ram.sv =====
// Generic single-port RAM with registered read.
module adam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hdl/adam_divsqrt.sv =====
// Shared iterative unit: restoring 128/64 division or 96-bit square root, one bit a cycle.
module adam_divsqrt
    import adam_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_unit_cmd    i_cmd,
    input  logic [127:0] i_num,
    input  logic [63:0]  i_den,
    input  logic [63:0]  i_cap,
    output logic         o_done,
    output logic [63:0]  o_result
);
    logic         r_busy, n_busy;
    logic         r_sqrt;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [64:0]  r_rem;
    logic [63:0]  r_q;
    logic [63:0]  r_den;
    logic [63:0]  r_cap;
    logic         r_over;
    logic         r_done;

    logic [65:0]  div_try;
    logic [64:0]  div_sh;
    logic [66:0]  sq_r;
    logic [66:0]  sq_t;
    logic         last;

    always_comb begin
        div_sh  = {r_rem[63:0], r_num[127]};
        div_try = {1'b0, div_sh} - {2'b00, r_den};
        sq_r    = {r_rem, r_num[127:126]};
        sq_t    = {1'b0, r_q, 2'b01};
        last    = (r_cnt == 7'd0);
        n_busy  = r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_cmd.is_sqrt;
                r_num  <= i_num;
                r_den  <= i_den;
                r_cap  <= i_cap;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_cnt  <= i_cmd.is_sqrt ? 7'd47 : 7'd127;
            end else if (n_busy) begin
                if (r_sqrt) begin
                    r_num <= {r_num[125:0], 2'b00};
                    if (sq_r >= sq_t) begin
                        r_rem <= 65'(sq_r - sq_t);
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= sq_r[64:0];
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                end else begin
                    r_num <= {r_num[126:0], 1'b0};
                    if (!div_try[65]) begin
                        r_rem <= div_try[64:0];
                        if (r_cnt >= 7'd64) begin
                            r_over <= 1'b1;
                        end else begin
                            r_q <= {r_q[62:0], 1'b1};
                        end
                    end else begin
                        r_rem <= div_sh;
                        if (r_cnt < 7'd64) begin
                            r_q <= {r_q[62:0], 1'b0};
                        end
                    end
                end
                r_cnt <= r_cnt - 7'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_sqrt ? r_q : ((r_over || r_q > r_cap) ? r_cap : r_q);
endmodule

// ===== hdl/adam_optimizer_update.sv =====
// Top level of the fixed-point Adam optimizer update.
//
// One element enters on the input channel (i_valid/o_ready): its moment slot,
// value, gradient and a flag that opens a new optimizer step. The block reads
// both moment entries, updates them with a shared 32x32 multiplier and writes
// them back. Two divisions, one square root and a third division then run
// through one shared bit-serial unit. No new element is taken until the result
// of the last one is in the output register; o_ready stays low meanwhile.
// When either bias correction is still zero the divisions and the square root
// are skipped. A zero denominator skips the last division.
// After reset the block first clears both moment stores, one slot a cycle,
// with o_ready low; configuration writes are taken throughout.
// The result waits in an output register (o_valid/i_ready); a new element is
// accepted once the previous result has been transferred or in the same
// cycle. Reset restores the register defaults, the step count and beta powers.
module adam_optimizer_update
    import adam_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SLOT_W-1:0]       i_slot,
    input  logic signed [VAL_W-1:0] i_param_value,
    input  logic signed [VAL_W-1:0] i_gradient,
    input  logic                    i_first_of_step,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [VAL_W-1:0] o_new_param_value
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_POW1, S_POW2, S_READ, S_MDIFF, S_MMUL, S_VMUL,
        S_WRITE, S_DIV1, S_W1, S_DIV2, S_W2, S_SQRT, S_W3, S_ULO, S_UHI,
        S_DIV3, S_W4, S_DONE
    } t_state;

    t_state r_state;

    logic [COEF_W-1:0] r_lr, r_b1, r_b2;
    logic [EPS_W-1:0]  r_eps;
    logic [31:0]       r_step_count;
    logic [COEF_W-1:0] r_b1p, r_b2p;

    logic [SLOT_W-1:0]       r_slot;
    logic signed [VAL_W-1:0] r_param;
    logic signed [VAL_W-1:0] r_grad;
    logic                    r_first;
    logic [SLOT_W-1:0]       r_clr;

    logic [63:0]  r_mag;
    logic         r_neg;
    logic [63:0]  r_acc;
    logic signed [MEAN_W-1:0] r_m;
    logic [VAR_W-1:0]         r_v;
    logic         r_mneg;
    logic [63:0]  r_mhat;
    logic [63:0]  r_vhat;
    logic [63:0]  r_den;
    logic [95:0]  r_prod;
    logic signed [VAL_W-1:0] r_out;
    logic         r_out_valid;

    logic                     mem_we;
    logic [SLOT_W-1:0]        mem_addr;
    logic [MEAN_W-1:0]        mean_rd;
    logic [VAR_W-1:0]         var_rd;
    logic [MEAN_W-1:0]        mean_wd;
    logic [VAR_W-1:0]         var_wd;

    t_unit_cmd    ucmd;
    logic [127:0] u_num;
    logic [63:0]  u_den, u_cap, u_res;
    logic         u_done;

    logic [COEF_W-1:0] b1c, b2c, bc1, bc2;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [95:0]  mulq_full;
    logic [31:0]  gq_mag;
    logic [63:0]  sq;
    logic [63:0]  m_mag;
    logic signed [64:0] gq, mdiff_s, vdiff_s, rnd_s;
    logic [64:0]  den_sum;
    logic signed [34:0] res_wide;

    assign b1c = clamp_beta(r_b1);
    assign b2c = clamp_beta(r_b2);
    assign bc1 = ONE_Q30 - r_b1p;
    assign bc2 = ONE_Q30 - r_b2p;

    assign mul_p  = 64'(mul_a) * 64'(mul_b);
    assign gq_mag = r_grad[31] ? 32'(-r_grad) : 32'(r_grad);
    assign gq     = 65'(signed'(r_grad)) <<< 16;
    assign sq     = 64'(gq_mag) * 64'(gq_mag);
    assign mdiff_s = 65'(signed'(mean_rd)) - gq;
    assign vdiff_s = signed'({1'b0, var_rd}) - signed'({1'b0, sq});
    assign mulq_full = r_prod;
    assign rnd_s  = r_neg ? -signed'({1'b0, r_acc}) : signed'({1'b0, r_acc});
    assign den_sum = {1'b0, r_vhat} + 65'(r_eps);
    assign m_mag  = r_m[MEAN_W-1] ? 64'(-65'(signed'(r_m))) : 64'(r_m);

    // Multiplier operand select: magnitudes up to 64 bits are done as two halves.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_POW1:  begin mul_a = 32'(r_b1p); mul_b = 32'(b1c); end
            S_POW2:  begin mul_a = 32'(r_b2p); mul_b = 32'(b2c); end
            S_MMUL, S_VMUL, S_ULO: begin mul_a = r_mag[31:0];  mul_b = 32'(r_first ? r_lr : 31'(r_lr)); end
            S_WRITE, S_UHI: begin mul_a = r_mag[63:32]; mul_b = 32'(r_lr); end
            default: ;
        endcase
        if (r_state == S_MMUL || r_state == S_WRITE && !r_first) begin
            mul_b = 32'(b1c);
        end
        if (r_state == S_VMUL || r_state == S_WRITE && r_first) begin
            mul_b = 32'(b2c);
        end
    end

    assign mem_addr = (r_state == S_CLEAR) ? r_clr : r_slot;
    assign mem_we   = (r_state == S_CLEAR) || (r_state == S_DIV1);
    assign mean_wd  = (r_state == S_CLEAR) ? '0 : r_m;
    assign var_wd   = (r_state == S_CLEAR) ? '0 : r_v;

    adam_ram #(.WIDTH(MEAN_W), .DEPTH(SLOT_COUNT)) u_mean (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mean_wd), .o_rdata(mean_rd)
    );
    adam_ram #(.WIDTH(VAR_W), .DEPTH(SLOT_COUNT)) u_var (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(var_wd), .o_rdata(var_rd)
    );

    always_comb begin
        ucmd  = '0;
        u_num = '0;
        u_den = '0;
        u_cap = MHAT_CAP;
        case (r_state)
            S_DIV1: begin
                ucmd.start = 1'b1;
                u_num = 128'({m_mag, 30'd0});
                u_den = 64'(bc1);
            end
            S_DIV2: begin
                ucmd.start = 1'b1;
                u_num = 128'({r_v, 30'd0});
                u_den = 64'(bc2);
                u_cap = '1;
            end
            S_SQRT: begin
                ucmd.start   = 1'b1;
                ucmd.is_sqrt = 1'b1;
                u_num = {r_vhat, 64'd0};
            end
            S_DIV3: begin
                ucmd.start = 1'b1;
                u_num = 128'(r_prod);
                u_den = {r_den[49:0], 14'd0};
                u_cap = UPDATE_CAP;
            end
            default: ;
        endcase
    end

    adam_divsqrt u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(ucmd), .i_num(u_num),
        .i_den(u_den), .i_cap(u_cap), .o_done(u_done), .o_result(u_res)
    );

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_lr         <= LR_RESET;
            r_b1         <= B1_RESET;
            r_b2         <= B2_RESET;
            r_eps        <= EPS_RESET;
            r_step_count <= '0;
            r_b1p        <= ONE_Q30;
            r_b2p        <= ONE_Q30;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LEARNING_RATE: r_lr  <= i_cfg_data[COEF_W-1:0];
                    REG_BETA_ONE:      r_b1  <= i_cfg_data[COEF_W-1:0];
                    REG_BETA_TWO:      r_b2  <= i_cfg_data[COEF_W-1:0];
                    REG_EPSILON:       r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SLOT_W'(SLOT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_slot  <= i_slot;
                        r_param <= i_param_value;
                        r_grad  <= i_gradient;
                        r_first <= 1'b0;
                        if (i_first_of_step) begin
                            r_step_count <= r_step_count + 32'd1;
                            r_state <= S_POW1;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_POW1: begin
                    r_b1p <= COEF_W'((mul_p + 64'h2000_0000) >> 30);
                    r_state <= S_POW2;
                end
                S_POW2: begin
                    r_b2p <= COEF_W'((mul_p + 64'h2000_0000) >> 30);
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_MDIFF;
                S_MDIFF: begin
                    r_neg   <= mdiff_s[64];
                    r_mag   <= mdiff_s[64] ? 64'(-mdiff_s) : 64'(mdiff_s);
                    r_prod  <= '0;
                    r_state <= S_MMUL;
                end
                S_MMUL: begin
                    r_prod  <= 96'(mul_p);
                    r_first <= 1'b0;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!r_first) begin
                        r_acc <= 64'((r_prod + (96'(mul_p) << 32) + 96'h2000_0000) >> 30);
                        r_first <= 1'b1;
                        r_neg <= vdiff_s[64];
                        r_mag <= vdiff_s[64] ? 64'(-vdiff_s) : 64'(vdiff_s);
                        r_state <= S_VMUL;
                    end else begin
                        r_v <= VAR_W'(signed'({1'b0, sq}) +
                               (r_neg ? -signed'({1'b0, 64'((r_prod + (96'(mul_p) << 32)
                                + 96'h2000_0000) >> 30)}) : signed'({1'b0,
                                64'((r_prod + (96'(mul_p) << 32) + 96'h2000_0000) >> 30)})));
                        r_state <= S_DIV1;
                    end
                    if (!r_first) begin
                        r_m <= MEAN_W'(gq + (mdiff_s[64]
                               ? -signed'({1'b0, 64'((r_prod + (96'(mul_p) << 32)
                                 + 96'h2000_0000) >> 30)})
                               : signed'({1'b0, 64'((r_prod + (96'(mul_p) << 32)
                                 + 96'h2000_0000) >> 30)})));
                    end
                end
                S_VMUL: begin
                    r_prod  <= 96'(mul_p);
                    r_state <= S_WRITE;
                end
                S_DIV1: begin
                    r_mneg <= r_m[MEAN_W-1];
                    r_mag  <= m_mag;
                    if (bc1 == '0 || bc2 == '0) begin
                        r_out   <= r_param;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_W1;
                    end
                end
                S_W1: if (u_done) begin r_mhat <= u_res; r_state <= S_DIV2; end
                S_DIV2: r_state <= S_W2;
                S_W2: if (u_done) begin r_vhat <= u_res; r_state <= S_SQRT; end
                S_SQRT: r_state <= S_W3;
                S_W3: if (u_done) begin
                    r_vhat  <= u_res;
                    r_mag   <= r_mhat;
                    r_state <= S_ULO;
                end
                S_ULO: begin
                    r_den   <= den_sum[63:0];
                    r_prod  <= 96'(mul_p);
                    r_state <= S_UHI;
                end
                S_UHI: begin
                    r_prod <= r_prod + (96'(mul_p) << 32);
                    if (r_den == '0) begin
                        r_acc   <= (r_mhat != '0) ? UPDATE_CAP : '0;
                        r_state <= S_W4;
                    end else begin
                        r_state <= S_DIV3;
                    end
                end
                S_DIV3: r_state <= S_W4;
                S_W4: begin
                    if (r_den == '0 || u_done) begin
                        r_out <= (res_wide > 35'sd2147483647) ? 32'sh7FFF_FFFF :
                                 (res_wide < -35'sd2147483648) ? 32'sh8000_0000 :
                                 VAL_W'(res_wide);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        logic signed [34:0] u_s;
        u_s = (r_den == '0) ? signed'(35'(r_acc)) : signed'(35'(u_res));
        res_wide = r_mneg ? 35'(r_param) + u_s : 35'(r_param) - u_s;
    end

    assign o_valid           = r_out_valid;
    assign o_new_param_value = r_out;
    logic unused;
    assign unused = ^{mulq_full[0], rnd_s[0], r_step_count[0]};
endmodule

// ===== hdl/adam_checker.sv =====
// Port-level assertions for the Adam optimizer update block.
module adam_checker
    import adam_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic signed [VAL_W-1:0] o_new_param_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_param_value))
        else $error("result changed while stalled");
    a_no_ready_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready or valid right after reset");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after a transfer");
    a_no_result_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result too early");
endmodule

bind adam_optimizer_update adam_checker u_adam_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_new_param_value(o_new_param_value)
);
